// ===== design/gap_buffer_text_store_defines.svh =====
// Assertion macros for the gap buffer text store.
`ifndef GAP_BUFFER_TEXT_STORE_DEFINES_SVH
`define GAP_BUFFER_TEXT_STORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GBTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gap buffer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GBTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gap buffer check failed");

`endif

// ===== design/gbts_pkg.sv =====
// Shared types and field layout for the gap buffer text store.
package gbts_pkg;

	localparam int MODE_W    = 3;
	localparam int BYTE_W    = 8;
	localparam int POS_W     = 13;
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 40;
	localparam int M_PAD_W   = M_TDATA_W - (BYTE_W + 2 * POS_W + 1);

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT      = 3'd0,
		MODE_ERASE_BACK  = 3'd1,
		MODE_ERASE_FWD   = 3'd2,
		MODE_MOVE        = 3'd3,
		MODE_ERASE_RANGE = 3'd4,
		MODE_READ        = 3'd5
	} mode_t;

endpackage

// ===== design/gbts_ram.sv =====
// Generic simple dual-port RAM with registered read.
module gbts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/gap_buffer_text_store.sv =====
// Gap buffer text store: CAPACITY bytes of text held in one RAM around a movable
// gap whose start is the cursor. One item is taken at a time and gives one result.
// Every item passes through an execute state and a finish state before its result
// is registered; a read issues one RAM read in the execute state. A cursor move or
// range erase that has to shift text also passes through a move state, which copies
// one byte per cycle through the RAM's read and write ports over the distance the
// gap travels. The finish state waits until the output register is free. A new item
// is taken while the previous result still waits on the output register.
`include "gap_buffer_text_store_defines.svh"

module gap_buffer_text_store #(
	parameter int CAPACITY = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// data_byte[7:0], count[20:8], position_a[33:21], position_b[46:34], zero pad
	input  logic [gbts_pkg::S_TDATA_W-1:0]  s_tdata,
	// mode[2:0]
	input  logic [gbts_pkg::MODE_W-1:0]     s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// read_data[7:0], cursor_position[20:8], text_length[33:21], overflow_flag[34], pad
	output logic [gbts_pkg::M_TDATA_W-1:0]  m_tdata
);

	localparam int GW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int PW = (GW > gbts_pkg::POS_W) ? GW : gbts_pkg::POS_W;
	localparam logic [GW-1:0] CAP_G = GW'(CAPACITY);

	typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_MOVE, ST_FIN} state_t;

	state_t                         state_q;
	gbts_pkg::mode_t                mode_q;
	logic [gbts_pkg::BYTE_W-1:0]    byte_q;
	logic [gbts_pkg::POS_W-1:0]     cnt_q, pa_q, pb_q;
	logic [GW-1:0]                  gs_q, gf_q, n_q;
	logic [AW-1:0]                  src_q, dst_q, wr_addr_s1;
	logic                           dir_q, wr_pend_s1, ovf_q, rd_hit_q;
	logic                           m_tvalid_q;
	logic [gbts_pkg::M_TDATA_W-1:0] m_tdata_q;

	logic                ram_we, ram_re;
	logic [AW-1:0]       ram_waddr, ram_raddr;
	logic [7:0]          ram_wdata, ram_rdata;

	logic [GW-1:0] len, after, from_g, to_g, gf_range, back_k, fwd_k, rd_off;
	logic [PW-1:0] len_p, gs_p, pa_p, pb_p, cnt_p, from_p, to_p;
	logic [AW-1:0] rd_idx;
	logic          range_ok, rd_hit, can_insert, out_free;
	logic          is_range, shift_dn, shift_up;
	logic [7:0]    rd_byte;

	// gap bookkeeping
	always_comb begin
		len        = gs_q + (CAP_G - gf_q);
		after      = CAP_G - gf_q;
		len_p      = PW'(len);
		gs_p       = PW'(gs_q);
		pa_p       = PW'(pa_q);
		pb_p       = PW'(pb_q);
		cnt_p      = PW'(cnt_q);
		from_p     = (pa_p > len_p) ? len_p : pa_p;
		from_g     = from_p[GW-1:0];
		to_p       = (pb_p > len_p) ? len_p : pb_p;
		to_g       = (mode_q == gbts_pkg::MODE_MOVE) ? from_g : to_p[GW-1:0];
		range_ok   = from_g <= to_g;
		// every ordered range case (from <= to) ends with the gap spanning [from, gf + to - gs)
		gf_range   = gf_q + to_g - gs_q;
		is_range   = mode_q == gbts_pkg::MODE_MOVE || mode_q == gbts_pkg::MODE_ERASE_RANGE;
		shift_dn   = is_range && range_ok && gs_q < from_g;
		shift_up   = is_range && range_ok && gs_q > to_g;
		back_k     = (cnt_p > gs_p) ? gs_q : cnt_p[GW-1:0];
		fwd_k      = (cnt_p > PW'(after)) ? after : cnt_p[GW-1:0];
		can_insert = gs_q < gf_q;
		rd_hit     = pa_p < len_p;
		rd_off     = pa_p[GW-1:0] + gf_q - gs_q;
		rd_idx     = (pa_p < gs_p) ? pa_p[AW-1:0] : rd_off[AW-1:0];
		rd_byte    = rd_hit_q ? ram_rdata : 8'd0;
		out_free   = !m_tvalid_q || m_tready;
	end

	// RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wr_addr_s1;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = src_q;
		unique case (state_q)
			ST_EXEC: begin
				if (mode_q == gbts_pkg::MODE_INSERT && can_insert) begin
					ram_we    = 1'b1;
					ram_waddr = gs_q[AW-1:0];
					ram_wdata = byte_q;
				end
				if (mode_q == gbts_pkg::MODE_READ && rd_hit) begin
					ram_re    = 1'b1;
					ram_raddr = rd_idx;
				end
			end
			ST_MOVE: begin
				ram_we = wr_pend_s1;
				ram_re = n_q != '0;
			end
			default: begin
			end
		endcase
	end

	gbts_ram #(
		.WIDTH (8),
		.DEPTH (CAPACITY)
	) u_text_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mode_q     <= gbts_pkg::MODE_INSERT;
			byte_q     <= '0;
			cnt_q      <= '0;
			pa_q       <= '0;
			pb_q       <= '0;
			gs_q       <= '0;
			gf_q       <= CAP_G;
			n_q        <= '0;
			src_q      <= '0;
			dst_q      <= '0;
			dir_q      <= 1'b0;
			wr_pend_s1 <= 1'b0;
			wr_addr_s1 <= '0;
			ovf_q      <= 1'b0;
			rd_hit_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			// the finish state reloads the output register on its own
			if (m_tvalid_q && m_tready && state_q != ST_FIN) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						mode_q  <= gbts_pkg::mode_t'(s_tuser);
						byte_q  <= s_tdata[7:0];
						cnt_q   <= s_tdata[20:8];
						pa_q    <= s_tdata[33:21];
						pb_q    <= s_tdata[46:34];
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					ovf_q    <= mode_q == gbts_pkg::MODE_INSERT && !can_insert;
					rd_hit_q <= mode_q == gbts_pkg::MODE_READ && rd_hit;
					state_q  <= (shift_dn || shift_up) ? ST_MOVE : ST_FIN;
					unique case (mode_q)
						gbts_pkg::MODE_INSERT: begin
							if (can_insert) begin
								gs_q <= gs_q + 1'b1;
							end
						end
						gbts_pkg::MODE_ERASE_BACK: gs_q <= gs_q - back_k;
						gbts_pkg::MODE_ERASE_FWD:  gf_q <= gf_q + fwd_k;
						gbts_pkg::MODE_MOVE, gbts_pkg::MODE_ERASE_RANGE: begin
							if (range_ok) begin
								gs_q <= from_g;
								gf_q <= gf_range;
							end
							if (shift_dn) begin
								// text after the gap shifts down
								dir_q <= 1'b1;
								n_q   <= from_g - gs_q;
								src_q <= gf_q[AW-1:0];
								dst_q <= gs_q[AW-1:0];
							end else if (shift_up) begin
								// text before the gap shifts up, top byte first
								dir_q <= 1'b0;
								n_q   <= gs_q - to_g;
								src_q <= gs_q[AW-1:0] - 1'b1;
								dst_q <= gf_q[AW-1:0] - 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
				ST_MOVE: begin
					// read at src this cycle, write at dst the next
					if (n_q != '0) begin
						wr_pend_s1 <= 1'b1;
						wr_addr_s1 <= dst_q;
						n_q        <= n_q - 1'b1;
						src_q      <= dir_q ? src_q + 1'b1 : src_q - 1'b1;
						dst_q      <= dir_q ? dst_q + 1'b1 : dst_q - 1'b1;
					end else begin
						wr_pend_s1 <= 1'b0;
						state_q    <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {{gbts_pkg::M_PAD_W{1'b0}}, ovf_q,
							len_p[gbts_pkg::POS_W-1:0], gs_p[gbts_pkg::POS_W-1:0],
							rd_byte};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`GBTS_ASSERT_NOW(a_gap_order, clk, arst_n, 1'b1, gs_q <= gf_q && gf_q <= CAP_G)
	`GBTS_ASSERT_NOW(a_copy_no_overlap, clk, arst_n, ram_we && ram_re, ram_waddr != ram_raddr)
	`GBTS_ASSERT_NEXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready)

endmodule

// ===== tb/sv/gap_buffer_text_store_tb.sv =====
// Self-checking testbench for the gap buffer text store.
`timescale 1ns / 100ps

module gap_buffer_text_store_tb;

	typedef logic [gbts_pkg::MODE_W-1:0] op_t;
	typedef logic [gbts_pkg::BYTE_W-1:0] byte_t;
	typedef logic [gbts_pkg::POS_W-1:0]  pos_t;

	localparam int CAPACITY = 4096;
	localparam pos_t POS_MAX = '1;
	localparam int MAX_GAP = 13;
	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_ITEMS = 1820;
	localparam int SOFT_TEXT_LIMIT = 320;
	// spare mode codes, no operation
	localparam op_t MODE_SPARE_6 = 3'd6;
	localparam op_t MODE_SPARE_7 = 3'd7;

	typedef struct packed {
		byte_t read_byte;
		pos_t  cursor;
		pos_t  length;
		logic  overflow;
	} status_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [gbts_pkg::S_TDATA_W-1:0]   s_tdata = '0;
	op_t                              s_tuser = '0;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [gbts_pkg::M_TDATA_W-1:0]   m_tdata;

	gap_buffer_text_store #(.CAPACITY(CAPACITY)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow copy of the store
	byte_t shadow_text [CAPACITY];
	int gap_head;
	int gap_tail;

	status_t expected_status [$];
	int mismatches = 0;
	int results_seen = 0;
	int items_sent = 0;
	bit src_quiet = 1'b0;
	bit sink_quiet = 1'b0;
	int sink_hold = 0;
	int sink_next;
	int stall_cycles = 0;

	function automatic int text_size();
		return gap_head + CAPACITY - gap_tail;
	endfunction

	function automatic int saturate_pos(int p);
		return (p > text_size()) ? text_size() : p;
	endfunction

	function automatic void drop_before(int n);
		if (n > gap_head)
			n = gap_head;
		gap_head -= n;
	endfunction

	function automatic void drop_after(int n);
		int tail_bytes;
		tail_bytes = CAPACITY - gap_tail;
		if (n > tail_bytes)
			n = tail_bytes;
		gap_tail += n;
	endfunction

	function automatic void slide_gap(int target);
		while (gap_head < target && gap_tail < CAPACITY) begin
			shadow_text[gap_head] = shadow_text[gap_tail];
			gap_head++;
			gap_tail++;
		end
		while (gap_head > target && gap_head > 0) begin
			gap_head--;
			gap_tail--;
			shadow_text[gap_tail] = shadow_text[gap_head];
		end
	endfunction

	function automatic status_t apply_edit(op_t op, byte_t d, pos_t cnt, pos_t pa, pos_t pb);
		status_t s;
		int lo;
		int hi;
		int g;
		int p;
		int idx;
		s = '0;
		case (op)
			gbts_pkg::MODE_INSERT: begin
				if (gap_head < gap_tail) begin
					shadow_text[gap_head] = d;
					gap_head++;
				end else begin
					s.overflow = 1'b1;
				end
			end
			gbts_pkg::MODE_ERASE_BACK: drop_before(int'(cnt));
			gbts_pkg::MODE_ERASE_FWD: drop_after(int'(cnt));
			gbts_pkg::MODE_MOVE: slide_gap(saturate_pos(int'(pa)));
			gbts_pkg::MODE_ERASE_RANGE: begin
				lo = saturate_pos(int'(pa));
				hi = saturate_pos(int'(pb));
				g = gap_head;
				if (lo <= hi) begin
					if (lo <= g && g <= hi) begin
						drop_before(g - lo);
						drop_after(hi - g);
					end else if (g < lo) begin
						slide_gap(lo);
						drop_after(hi - lo);
					end else begin
						slide_gap(hi);
						drop_before(hi - lo);
					end
				end
			end
			gbts_pkg::MODE_READ: begin
				p = int'(pa);
				if (p < text_size()) begin
					idx = (p < gap_head) ? p : p + (gap_tail - gap_head);
					if (idx < CAPACITY)
						s.read_byte = shadow_text[idx];
				end
			end
			default: ;
		endcase
		s.cursor = gap_head[gbts_pkg::POS_W-1:0];
		s.length = pos_t'(text_size());
		return s;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH result %0d: %s", results_seen, msg);
		mismatches++;
	endtask

	// one item: optional idle gap, then hold valid until the transfer
	task automatic send_edit(input op_t op, input byte_t d, input pos_t cnt, input pos_t pa,
		input pos_t pb);
		int gap;
		gap = src_quiet ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {1'b0, pb, pa, cnt, d};
		do @(posedge clk); while (!s_tready);
		expected_status.push_back(apply_edit(op, d, cnt, pa, pb));
		items_sent++;
	endtask

	task automatic check_status(input logic [gbts_pkg::M_TDATA_W-1:0] word);
		status_t want;
		if (expected_status.size() == 0) begin
			report_mismatch($sformatf("no pending item, got word %h", word));
		end else begin
			want = expected_status.pop_front();
			if (word[7:0] !== want.read_byte)
				report_mismatch($sformatf("read_data got %0d expected %0d",
					word[7:0], want.read_byte));
			if (word[20:8] !== want.cursor)
				report_mismatch($sformatf("cursor_position got %0d expected %0d",
					word[20:8], want.cursor));
			if (word[33:21] !== want.length)
				report_mismatch($sformatf("text_length got %0d expected %0d",
					word[33:21], want.length));
			if (word[34] !== want.overflow)
				report_mismatch($sformatf("overflow_flag got %0b expected %0b",
					word[34], want.overflow));
		end
		results_seen++;
	endtask

	// result side: check each transfer, then draw the next stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_hold <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_status(m_tdata);
				sink_next = sink_quiet ? 0 : $urandom_range(0, MAX_GAP);
			end else begin
				sink_next = (sink_hold > 0) ? sink_hold - 1 : 0;
			end
			sink_hold <= sink_next;
			m_tready <= (sink_next == 0);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout after %0d idle cycles", stall_cycles);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	task automatic test_empty_store();
		send_edit(gbts_pkg::MODE_READ, 8'h00, 13'd0, 13'd0, 13'd0);
		send_edit(gbts_pkg::MODE_ERASE_BACK, 8'h00, 13'd1, 13'd0, 13'd0);
		send_edit(gbts_pkg::MODE_ERASE_FWD, 8'h00, 13'd1, 13'd0, 13'd0);
		send_edit(gbts_pkg::MODE_MOVE, 8'h00, 13'd0, 13'd4096, 13'd0);
		send_edit(gbts_pkg::MODE_ERASE_RANGE, 8'h00, 13'd0, 13'd0, POS_MAX);
		send_edit(MODE_SPARE_6, 8'hFF, POS_MAX, POS_MAX, POS_MAX);
		send_edit(MODE_SPARE_7, 8'h00, 13'd0, 13'd0, 13'd0);
	endtask

	task automatic test_edit_paths();
		send_edit(gbts_pkg::MODE_INSERT, 8'h00, 13'd0, 13'd0, 13'd0);
		send_edit(gbts_pkg::MODE_INSERT, 8'hFF, 13'd0, 13'd0, 13'd0);
		send_edit(gbts_pkg::MODE_INSERT, 8'hA5, 13'd0, 13'd0, 13'd0);
		send_edit(gbts_pkg::MODE_INSERT, 8'h5A, 13'd0, 13'd0, 13'd0);
		send_edit(gbts_pkg::MODE_INSERT, 8'h31, 13'd0, 13'd0, 13'd0);
		send_edit(gbts_pkg::MODE_INSERT, 8'h32, 13'd0, 13'd0, 13'd0);
		send_edit(gbts_pkg::MODE_READ, 8'h00, 13'd0, 13'd0, 13'd0);
		send_edit(gbts_pkg::MODE_READ, 8'h00, 13'd0, 13'd5, 13'd0);
		send_edit(gbts_pkg::MODE_READ, 8'h00, 13'd0, 13'd6, 13'd0);   // one past the end
		send_edit(gbts_pkg::MODE_MOVE, 8'h00, 13'd0, 13'd2, 13'd0);
		send_edit(gbts_pkg::MODE_READ, 8'h00, 13'd0, 13'd1, 13'd0);
		send_edit(gbts_pkg::MODE_READ, 8'h00, 13'd0, 13'd4, 13'd0);   // behind the gap
		send_edit(gbts_pkg::MODE_ERASE_RANGE, 8'h00, 13'd0, 13'd1, 13'd4);  // cursor inside
		send_edit(gbts_pkg::MODE_INSERT, 8'h77, 13'd0, 13'd0, 13'd0);
		send_edit(gbts_pkg::MODE_ERASE_RANGE, 8'h00, 13'd0, 13'd3, 13'd4);  // after cursor
		send_edit(gbts_pkg::MODE_ERASE_RANGE, 8'h00, 13'd0, 13'd0, 13'd1);  // before cursor
		send_edit(gbts_pkg::MODE_ERASE_RANGE, 8'h00, 13'd0, 13'd2, 13'd1);  // reversed
		send_edit(gbts_pkg::MODE_ERASE_BACK, 8'h00, POS_MAX, 13'd0, 13'd0);
		send_edit(gbts_pkg::MODE_ERASE_FWD, 8'h00, POS_MAX, 13'd0, 13'd0);
		send_edit(gbts_pkg::MODE_MOVE, 8'h00, 13'd0, POS_MAX, 13'd0);
	endtask

	function automatic pos_t pick_position();
		if ($urandom_range(0, 9) == 0)
			return pos_t'($urandom_range(0, POS_MAX));
		return pos_t'($urandom_range(0, text_size()));
	endfunction

	task automatic test_random_edits();
		int r;
		int len;
		op_t op;
		pos_t cnt;
		pos_t pa;
		pos_t pb;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0) begin
				src_quiet = ($urandom_range(0, 3) == 0);
				sink_quiet = ($urandom_range(0, 3) == 0);
			end
			len = text_size();
			r = $urandom_range(0, 99);
			if (len > SOFT_TEXT_LIMIT && r < 40)
				r += 40;
			cnt = ($urandom_range(0, 7) == 0) ? pos_t'($urandom_range(0, POS_MAX))
				: pos_t'($urandom_range(0, 6));
			pa = pick_position();
			pb = ($urandom_range(0, 4) == 0) ? pick_position()
				: pos_t'(pa + $urandom_range(0, 12));
			if (r < 40)
				op = gbts_pkg::MODE_INSERT;
			else if (r < 48)
				op = gbts_pkg::MODE_ERASE_BACK;
			else if (r < 56)
				op = gbts_pkg::MODE_ERASE_FWD;
			else if (r < 70)
				op = gbts_pkg::MODE_MOVE;
			else if (r < 80)
				op = gbts_pkg::MODE_ERASE_RANGE;
			else if (r < 97) begin
				op = gbts_pkg::MODE_READ;
				if (len > 0 && $urandom_range(0, 9) != 0)
					pa = pos_t'($urandom_range(0, len - 1));
			end else
				op = $urandom_range(0, 1) ? MODE_SPARE_6 : MODE_SPARE_7;
			send_edit(op, byte_t'($urandom_range(0, 255)), cnt, pa, pb);
		end
		src_quiet = 1'b0;
		sink_quiet = 1'b0;
	endtask

	initial begin
		for (int i = 0; i < CAPACITY; i++)
			shadow_text[i] = '0;
		gap_head = 0;
		gap_tail = CAPACITY;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_store();
		test_edit_paths();
		test_random_edits();

		s_tvalid <= 1'b0;
		while (results_seen < items_sent)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
